[sv/timing_sample_statistics_assert.svh]
// Assertion macros for the timing sample statistics block.
// Included by timing_sample_statistics, which checks its own control logic.
`ifndef TIMING_SAMPLE_STATISTICS_ASSERT_SVH
`define TIMING_SAMPLE_STATISTICS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSS_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define TSS_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define TSS_ASSERT_IMP(label, clk, rst_n, a, c)
`define TSS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[sv/tss_pkg.sv]
// Package for the timing sample statistics block.
// Holds sizes, the sequencer state type and the divider control struct.
`default_nettype none
package tss_pkg;
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int TIME_BITS_DEF = 24;
	localparam int BYTES_BITS = 24;
	localparam int BW_BITS = 25;
	localparam int IDX_BITS = 10;
	localparam logic [BW_BITS-1:0] BW_SAT = 25'd33554430;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MEAN,
		ST_VAR,
		ST_VDIV,
		ST_SQRT,
		ST_MED_RD,
		ST_MED_SCAN,
		ST_MED_NEXT,
		ST_BW,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

[sv/tss_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on tss_pkg for the control struct.
`default_nettype none
module tss_div #(
	parameter int NUM_BITS = 64,
	parameter int DEN_BITS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [NUM_BITS-1:0] num,
	input wire logic [DEN_BITS-1:0] den,
	output tss_pkg::div_ctl_t ctl,
	output logic [NUM_BITS-1:0] quo
);
	import tss_pkg::*;
	localparam int CW = $clog2(NUM_BITS + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [NUM_BITS-1:0] n_q;
	logic [DEN_BITS:0] rem_q;
	logic [DEN_BITS:0] trial;
	logic [DEN_BITS:0] shifted;
	logic [DEN_BITS-1:0] den_q;

	assign shifted = {rem_q[DEN_BITS-1:0], n_q[NUM_BITS-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (!trial[DEN_BITS]) begin
				rem_q <= trial;
				quo <= {quo[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo <= {quo[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
endmodule
`default_nettype wire

[sv/timing_sample_statistics.sv]
// Samples are taken one per cycle while loading. After the last sample the block computes
// the statistics of the stored samples, and then the result is loaded.
// Throughput: one sample per cycle while loading; no sample is taken during the final pass.
// The result register frees the block once the result is loaded into it.
// Reset (arst_n low, asynchronous) clears the counters, flags and message size.
// The sample memory is not cleared; only entries written in the current set are read.
`default_nettype none
`include "timing_sample_statistics_assert.svh"
module timing_sample_statistics #(
	parameter int MAX_SAMPLES = tss_pkg::MAX_SAMPLES_DEF,
	parameter int TIME_BITS = tss_pkg::TIME_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [tss_pkg::BYTES_BITS-1:0] message_bytes,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [TIME_BITS-1:0] sample_time,
	input wire logic last,
	output logic out_valid,
	input wire logic out_stall,
	output logic [TIME_BITS-1:0] mean_time,
	output logic [TIME_BITS-1:0] std_dev,
	output logic [TIME_BITS-1:0] median_time,
	output logic [TIME_BITS-1:0] min_sample,
	output logic [tss_pkg::IDX_BITS-1:0] min_index,
	output logic [TIME_BITS-1:0] max_sample,
	output logic [tss_pkg::IDX_BITS-1:0] max_index,
	output logic [tss_pkg::BW_BITS-1:0] mean_bandwidth,
	output logic [tss_pkg::BW_BITS-1:0] median_bandwidth,
	output logic [tss_pkg::BW_BITS-1:0] low_bandwidth,
	output logic [tss_pkg::BW_BITS-1:0] high_bandwidth,
	output logic overflow
);
	import tss_pkg::*;
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = TIME_BITS + CW;
	localparam int QW = 2 * TIME_BITS + CW;
	localparam int PW = 2 * SW;
	localparam int XW = 2 * TIME_BITS;
	localparam int DW = 128;

	state_t state_q, state_d;
	logic [TIME_BITS-1:0] mem [MAX_SAMPLES];
	logic [CW-1:0] count_q;
	logic [SW-1:0] sum_q;
	logic [QW-1:0] sq_q;
	logic [TIME_BITS-1:0] min_q, max_q;
	logic [AW-1:0] minp_q, maxp_q;
	logic drop_q;
	logic [BYTES_BITS-1:0] bytes_q;
	logic [TIME_BITS-1:0] mean_q, med_q, sd_q;
	logic [BW_BITS-1:0] bw_q [4];
	logic [1:0] bw_sel_q;
	logic [CW-1:0] i_q, j_q;
	logic [CW-1:0] below_q, upto_q;
	logic [TIME_BITS-1:0] cand_q, rd_q;
	logic [DW-1:0] var_q;
	logic [63:0] vden_q;
	logic [63:0] vq_q;
	logic [63:0] sq_res_q, sq_bit_q;
	logic [5:0] step_q;
	logic [2:0] vphase_q;
	logic [PW-1:0] mul_a_q, prod_q;
	logic [SW-1:0] mul_b_q;
	logic [TIME_BITS-1:0] sq_in_s1;
	logic sq_v_s1, sq_v_s2;
	logic [XW-1:0] sq_s2;
	logic div_start;
	logic [DW-1:0] div_num;
	logic [63:0] div_den;
	div_ctl_t dctl;
	logic [DW-1:0] div_quo;
	logic accept, take_out;
	logic [TIME_BITS-1:0] bw_t;
	logic [SW-1:0] nm1;
	logic [CW-1:0] half_n;
	logic med_hit;

	assign accept = in_valid && !in_stall;
	assign take_out = out_valid && !out_stall;
	assign in_stall = (state_q != ST_LOAD);
	assign cfg_ready = (state_q == ST_LOAD);

	tss_div #(.NUM_BITS(DW), .DEN_BITS(64)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.ctl(dctl), .quo(div_quo)
	);

	always_comb begin
		case (bw_sel_q)
			2'd0: bw_t = mean_q;
			2'd1: bw_t = med_q;
			2'd2: bw_t = max_q;
			default: bw_t = min_q;
		endcase
	end

	assign nm1 = SW'(count_q) - SW'(1);
	assign half_n = count_q >> 1;
	assign med_hit = (below_q <= half_n) && (half_n < upto_q);

	always_comb begin
		div_start = 1'b0;
		div_num = DW'(sum_q);
		div_den = 64'(count_q);
		case (state_q)
			ST_MEAN: div_start = (step_q == 6'd0);
			ST_VDIV: begin
				div_start = (step_q == 6'd0);
				div_num = var_q;
				div_den = vden_q;
			end
			ST_BW: begin
				div_start = (step_q == 6'd0) && (bw_t != '0);
				div_num = DW'({bytes_q, 1'b0});
				div_den = 64'(bw_t);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		sq_in_s1 <= sample_time;
		sq_s2 <= XW'(sq_in_s1) * XW'(sq_in_s1);
		rd_q <= mem[(state_q == ST_MED_RD) ? i_q[AW-1:0] : j_q[AW-1:0]];
		if (accept && count_q < CW'(MAX_SAMPLES))
			mem[count_q[AW-1:0]] <= sample_time;
	end

	// Squares of stored samples pass through sq_in_s1 and sq_s2 before they are summed into sq_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s1 <= 1'b0;
			sq_v_s2 <= 1'b0;
		end else begin
			sq_v_s1 <= accept && count_q < CW'(MAX_SAMPLES);
			sq_v_s2 <= sq_v_s1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (accept && last) state_d = ST_MEAN;
			ST_MEAN: if (dctl.done) state_d = (count_q >= CW'(2)) ? ST_VAR : ST_MED_RD;
			ST_VAR: if (vphase_q == 3'd2 && mul_b_q == '0) state_d = ST_VDIV;
			ST_VDIV: if (dctl.done) state_d = ST_SQRT;
			ST_SQRT: if (step_q == 6'd34) state_d = ST_MED_RD;
			ST_MED_RD: state_d = (count_q == '0) ? ST_BW : ST_MED_SCAN;
			ST_MED_SCAN: if (j_q == count_q) state_d = ST_MED_NEXT;
			ST_MED_NEXT: state_d = (med_hit || i_q + CW'(1) == count_q) ? ST_BW : ST_MED_RD;
			ST_BW: if (bw_sel_q == 2'd3 && (dctl.done || (step_q == 6'd1 && bw_t == '0)))
				state_d = ST_OUT;
			ST_OUT: if (!out_valid || take_out) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			min_q <= '0;
			max_q <= '0;
			minp_q <= '0;
			maxp_q <= '0;
			drop_q <= 1'b0;
			bytes_q <= '0;
			out_valid <= 1'b0;
			step_q <= '0;
			vphase_q <= '0;
			bw_sel_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			if (take_out) out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) bytes_q <= message_bytes;
			if (sq_v_s2) sq_q <= sq_q + QW'(sq_s2);
			case (state_q)
				ST_LOAD: begin
					step_q <= '0;
					if (accept) begin
						if (count_q < CW'(MAX_SAMPLES)) begin
							if (count_q == '0) begin
								min_q <= sample_time;
								max_q <= sample_time;
								minp_q <= '0;
								maxp_q <= '0;
							end else if (sample_time < min_q) begin
								min_q <= sample_time;
								minp_q <= count_q[AW-1:0];
							end else if (sample_time > max_q) begin
								max_q <= sample_time;
								maxp_q <= count_q[AW-1:0];
							end
							count_q <= count_q + CW'(1);
							sum_q <= sum_q + SW'(sample_time);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_MEAN: begin
					step_q <= 6'd1;
					if (dctl.done) begin
						mean_q <= div_quo[TIME_BITS-1:0];
						step_q <= '0;
						sd_q <= '0;
						i_q <= '0;
						mul_a_q <= PW'(sq_q);
						mul_b_q <= SW'(count_q);
						prod_q <= '0;
						vphase_q <= '0;
					end
				end
				ST_VAR: begin
					// n*sq, then sum*sum, then n*(n-1), each by shift and add.
					step_q <= '0;
					if (mul_b_q != '0) begin
						if (mul_b_q[0]) prod_q <= prod_q + mul_a_q;
						mul_a_q <= mul_a_q << 1;
						mul_b_q <= mul_b_q >> 1;
					end else begin
						prod_q <= '0;
						vphase_q <= vphase_q + 3'd1;
						case (vphase_q)
							3'd0: begin
								var_q <= DW'(prod_q);
								mul_a_q <= PW'(sum_q);
								mul_b_q <= sum_q;
							end
							3'd1: begin
								var_q <= var_q - DW'(prod_q);
								mul_a_q <= PW'(count_q);
								mul_b_q <= nm1;
							end
							default: vden_q <= 64'(prod_q);
						endcase
					end
				end
				ST_VDIV: begin
					step_q <= 6'd1;
					if (dctl.done) begin
						vq_q <= (div_quo[DW-1:64] != '0) ? '1 : div_quo[63:0];
						sq_res_q <= '0;
						sq_bit_q <= 64'd1 << 62;
						step_q <= 6'd2;
					end
				end
				ST_SQRT: begin
					step_q <= step_q + 1'b1;
					if (vq_q >= sq_res_q + sq_bit_q) begin
						vq_q <= vq_q - (sq_res_q + sq_bit_q);
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					if (step_q == 6'd34) sd_q <= sq_res_q[TIME_BITS-1:0];
				end
				ST_MED_RD: begin
					j_q <= '0;
					below_q <= '0;
					upto_q <= '0;
					step_q <= '0;
					bw_sel_q <= '0;
					if (count_q == '0) med_q <= '0;
				end
				ST_MED_SCAN: begin
					// First cycle loads the candidate; later cycles compare memory reads.
					j_q <= j_q + 1'b1;
					if (j_q == '0) cand_q <= rd_q;
					else begin
						if (rd_q < cand_q) below_q <= below_q + 1'b1;
						if (rd_q <= cand_q) upto_q <= upto_q + 1'b1;
					end
				end
				ST_MED_NEXT: begin
					j_q <= '0;
					if (med_hit) begin
						med_q <= cand_q;
					end else begin
						i_q <= i_q + CW'(1);
						if (i_q + CW'(1) == count_q) med_q <= '0;
					end
				end
				ST_BW: begin
					if (step_q == 6'd0) step_q <= 6'd1;
					else if (bw_t == '0 || dctl.done) begin
						if (bw_t == '0) bw_q[bw_sel_q] <= BW_SAT;
						else if (div_quo > DW'(BW_SAT)) bw_q[bw_sel_q] <= BW_SAT;
						else bw_q[bw_sel_q] <= div_quo[BW_BITS-1:0];
						bw_sel_q <= bw_sel_q + 1'b1;
						step_q <= '0;
					end
				end
				ST_OUT: begin
					if (!out_valid || take_out) begin
						out_valid <= 1'b1;
						mean_time <= mean_q;
						std_dev <= sd_q;
						median_time <= med_q;
						min_sample <= min_q;
						min_index <= IDX_BITS'(minp_q);
						max_sample <= max_q;
						max_index <= IDX_BITS'(maxp_q);
						mean_bandwidth <= bw_q[0];
						median_bandwidth <= bw_q[1];
						low_bandwidth <= bw_q[2];
						high_bandwidth <= bw_q[3];
						overflow <= drop_q;
						count_q <= '0;
						sum_q <= '0;
						sq_q <= '0;
						min_q <= '0;
						max_q <= '0;
						minp_q <= '0;
						maxp_q <= '0;
						drop_q <= 1'b0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_MED_RD) j_q <= '0;
		end
	end

	`TSS_ASSERT_IMP(a_stall_busy, clk, arst_n, state_q != ST_LOAD, in_stall)
	`TSS_ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, count_q <= CW'(MAX_SAMPLES))
	`TSS_ASSERT_NEXT(a_last_leaves, clk, arst_n, accept && last, state_q == ST_MEAN)
	`TSS_ASSERT_IMP(a_div_idle, clk, arst_n, div_start, !dctl.busy)
endmodule
`default_nettype wire

[bench/timing_sample_statistics_test.sv]
// Self-checking testbench for timing_sample_statistics: drives sample sets,
// predicts each statistics result and compares it field by field.
// Depends on tss_pkg and the timing_sample_statistics RTL.
`timescale 1ns / 100ps
module timing_sample_statistics_test;
	import tss_pkg::*;

	localparam int TB = 24;
	localparam int DEPTH = 1024;

	typedef struct {
		bit [TB-1:0] mean_t;
		bit [TB-1:0] sd;
		bit [TB-1:0] median_t;
		bit [TB-1:0] min_t;
		bit [IDX_BITS-1:0] min_i;
		bit [TB-1:0] max_t;
		bit [IDX_BITS-1:0] max_i;
		bit [BW_BITS-1:0] bw_mean;
		bit [BW_BITS-1:0] bw_median;
		bit [BW_BITS-1:0] bw_low;
		bit [BW_BITS-1:0] bw_high;
		bit ovf;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [BYTES_BITS-1:0] message_bytes = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [TB-1:0] sample_time = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TB-1:0] mean_time, std_dev, median_time, min_sample, max_sample;
	logic [IDX_BITS-1:0] min_index, max_index;
	logic [BW_BITS-1:0] mean_bandwidth, median_bandwidth, low_bandwidth, high_bandwidth;
	logic overflow;

	timing_sample_statistics dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .message_bytes(message_bytes),
		.in_valid(in_valid), .in_stall(in_stall), .sample_time(sample_time), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.mean_time(mean_time), .std_dev(std_dev), .median_time(median_time),
		.min_sample(min_sample), .min_index(min_index), .max_sample(max_sample),
		.max_index(max_index), .mean_bandwidth(mean_bandwidth),
		.median_bandwidth(median_bandwidth), .low_bandwidth(low_bandwidth),
		.high_bandwidth(high_bandwidth), .overflow(overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state for the set being loaded.
	bit [TB-1:0] set_samples[$];
	bit set_dropped;
	bit [BYTES_BITS-1:0] msg_size;
	stats_t pending_stats[$];
	int mismatches = 0;
	bit eager = 1'b0;
	bit hold_start = 1'b0;
	logic hold_req = 1'b0;
	logic hold_on = 1'b0;

	function automatic bit [63:0] floor_sqrt(bit [63:0] v);
		bit [63:0] res = 0;
		bit [63:0] b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit [BW_BITS-1:0] bandwidth_of(bit [TB-1:0] t);
		bit [63:0] q;
		if (t == 0)
			return BW_SAT;
		q = (64'd2 * msg_size) / t;
		return (q > BW_SAT) ? BW_SAT : q[BW_BITS-1:0];
	endfunction

	function automatic stats_t summarize_set();
		stats_t r;
		bit [TB-1:0] sorted[$];
		bit [127:0] tsum = 0, ssum = 0, num, q;
		int n = set_samples.size();
		r.min_t = set_samples[0];
		r.max_t = set_samples[0];
		r.min_i = 0;
		r.max_i = 0;
		foreach (set_samples[i]) begin
			tsum += set_samples[i];
			ssum += 128'(set_samples[i]) * set_samples[i];
			if (set_samples[i] < r.min_t) begin
				r.min_t = set_samples[i];
				r.min_i = IDX_BITS'(i);
			end else if (set_samples[i] > r.max_t) begin
				r.max_t = set_samples[i];
				r.max_i = IDX_BITS'(i);
			end
		end
		r.mean_t = TB'(tsum / n);
		sorted = set_samples;
		sorted.sort();
		r.median_t = sorted[n / 2];
		r.sd = 0;
		if (n >= 2) begin
			num = ssum * n - tsum * tsum;
			q = num / (n * (n - 1));
			if (q[127:64] != 0)
				q = {64'd0, {64{1'b1}}};
			r.sd = TB'(floor_sqrt(q[63:0]));
		end
		r.bw_mean = bandwidth_of(r.mean_t);
		r.bw_median = bandwidth_of(r.median_t);
		r.bw_low = bandwidth_of(r.max_t);
		r.bw_high = bandwidth_of(r.min_t);
		r.ovf = set_dropped;
		return r;
	endfunction

	task automatic send_sample(bit [TB-1:0] t, bit is_last);
		int gap;
		in_valid <= 1'b1;
		sample_time <= t;
		last <= is_last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (set_samples.size() < DEPTH)
			set_samples.push_back(t);
		else
			set_dropped = 1'b1;
		if (is_last) begin
			pending_stats.push_back(summarize_set());
			set_samples.delete();
			set_dropped = 1'b0;
		end
		gap = eager ? 0 : int'($urandom_range(0, 12));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender pauses until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_msg_size(bit [BYTES_BITS-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		message_bytes <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		msg_size = v;
	endtask

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch in %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	task automatic check_field(string field, longint unsigned got, longint unsigned want);
		if (got != want)
			report_mismatch(field, got, want);
	endtask

	always @(posedge clk) begin
		hold_on <= hold_req;
	end

	// The long hold-off is counted here, apart from the test sequence.
	initial begin
		wait (hold_start);
		hold_req <= 1'b1;
		repeat (4000) @(posedge clk);
		hold_req <= 1'b0;
	end

	// Receiver: random stalls and the result check.
	int stall_left = 0;
	always @(posedge clk) begin
		stats_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_stats.size() == 0) begin
					report_mismatch("result transaction count", 1, 0);
				end else begin
					e = pending_stats.pop_front();
					check_field("mean_time", mean_time, e.mean_t);
					check_field("std_dev", std_dev, e.sd);
					check_field("median_time", median_time, e.median_t);
					check_field("min_sample", min_sample, e.min_t);
					check_field("min_index", min_index, e.min_i);
					check_field("max_sample", max_sample, e.max_t);
					check_field("max_index", max_index, e.max_i);
					check_field("mean_bandwidth", mean_bandwidth, e.bw_mean);
					check_field("median_bandwidth", median_bandwidth, e.bw_median);
					check_field("low_bandwidth", low_bandwidth, e.bw_low);
					check_field("high_bandwidth", high_bandwidth, e.bw_high);
					check_field("overflow", overflow, e.ovf);
				end
				stall_left = eager ? 0 : int'($urandom_range(0, 12));
			end
			if (hold_on || hold_req) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic bit [TB-1:0] random_time(int kind);
		case (kind)
			0: return TB'($urandom_range(0, 7));
			1: return TB'($urandom_range(1000, 1100));
			2: return TB'($urandom_range(24'hFFFFF0, 24'hFFFFFF));
			default: return TB'($urandom());
		endcase
	endfunction

	task automatic send_random_set(int n);
		int kind = int'($urandom_range(0, 4));
		for (int i = 0; i < n; i++)
			send_sample(random_time(kind), i == n - 1);
	endtask

	task automatic test_extremes();
		write_msg_size(24'hFFFFFF);
		send_sample(24'd0, 1'b1);
		send_sample(24'hFFFFFF, 1'b1);
		send_sample(24'hFFFFFF, 1'b0);
		send_sample(24'd0, 1'b1);
		send_sample(24'hAAAAAA, 1'b0);
		send_sample(24'h555555, 1'b1);
		write_msg_size(24'd0);
		send_sample(24'd1, 1'b0);
		send_sample(24'd3, 1'b1);
	endtask

	// Repeated minimum and maximum keep their first position.
	task automatic test_ties();
		write_msg_size(24'd1);
		send_sample(24'd50, 1'b0);
		send_sample(24'd9, 1'b0);
		send_sample(24'd80, 1'b0);
		send_sample(24'd9, 1'b0);
		send_sample(24'd80, 1'b0);
		send_sample(24'd50, 1'b1);
		send_sample(24'd7, 1'b0);
		send_sample(24'd7, 1'b0);
		send_sample(24'd7, 1'b1);
	endtask

	// A full store drops further samples; the last one is among those dropped.
	task automatic test_overflow();
		write_msg_size(24'd4096);
		for (int i = 0; i < DEPTH + 6; i++)
			send_sample(TB'($urandom_range(0, 4000)), i == DEPTH + 5);
		drain();
	endtask

	task automatic test_random_sets();
		int items = 0, n;
		while (items < 780) begin
			if (items % 200 < 8)
				write_msg_size(BYTES_BITS'($urandom()));
			eager = ($urandom_range(0, 5) == 0);
			n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 64))
				: int'($urandom_range(1, 16));
			send_random_set(n);
			items += n;
		end
		eager = 1'b0;
	endtask

	task automatic test_backpressure();
		write_msg_size(24'd12345);
		hold_start = 1'b1;
		eager = 1'b1;
		for (int s = 0; s < 4; s++)
			send_random_set(int'($urandom_range(2, 5)));
		eager = 1'b0;
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		msg_size = 0;
		set_dropped = 1'b0;
		test_extremes();
		test_ties();
		test_backpressure();
		test_random_sets();
		test_overflow();
		drain();
		repeat (700) @(posedge clk);
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("timing_sample_statistics_test OK");
		else
			$display("timing_sample_statistics_test NOT OK");
		$finish;
	end

	initial begin
		#120000000;
		$display("timing_sample_statistics_test NOT OK");
		$finish;
	end
endmodule
